@@ rtl/bsfr_pkg.sv @@
`timescale 1ns / 1ps

package bsfr_pkg;

	// frame geometry
	localparam int FRAME_LEN = 14;
	localparam int CW        = $clog2(FRAME_LEN);
	localparam int MAX_LEN   = FRAME_LEN - 6;

	// fixed positions within a frame
	localparam int ID_POS    = 1;
	localparam int LEN_POS   = 3;
	localparam int STAT_POS  = 4;
	localparam int BAT8_POS  = 8;
	localparam int LEVEL_POS = 9;

	// header bytes and classification constants
	localparam logic [7:0] SOF_BYTE   = 8'h3A;
	localparam logic [7:0] MARK_BYTE  = 8'hFF;
	localparam logic [7:0] FULL_LEVEL = 8'd100;

	// result queue
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	// configuration register indexes
	localparam logic REG_DEVICE_ID = 1'b0;
	localparam logic REG_IDLE_GAP  = 1'b1;

	localparam logic [7:0] IDLE_GAP_RESET = 8'd5;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_HDR  = 3'd1,
		ST_BAD_SUM  = 3'd2,
		ST_OTHER_ID = 3'd3,
		ST_BAD_LEN  = 3'd4
	} bsfr_status_t;

	typedef enum logic [1:0] {
		PACK_EMPTY    = 2'd0,
		PACK_RESERVED = 2'd1,
		PACK_FULL     = 2'd2,
		PACK_CHARGING = 2'd3
	} bsfr_bat_t;

	// one checked frame, front to back
	typedef struct packed {
		bsfr_status_t status;
		bsfr_bat_t    state;
		logic [7:0]   level;
	} bsfr_rec_t;

	// configuration as seen by the front
	typedef struct packed {
		logic [7:0] device_id;
		logic [7:0] idle_gap;
	} bsfr_cfg_t;

	// queue status towards the front
	typedef struct packed {
		logic full;
		logic empty;
	} bsfr_qstat_t;

endpackage

@@ rtl/bsfr_if.sv @@
`timescale 1ns / 1ps

// received words and ticks
interface bsfr_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;

	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

// frame results
interface bsfr_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] frame_status;
	logic [1:0] battery_state;
	logic [7:0] charge_level;
	logic       update_screen;

	modport source (output valid, output frame_status, output battery_state,
		output charge_level, output update_screen, input ready);
	modport sink (input valid, input frame_status, input battery_state,
		input charge_level, input update_screen, output ready);
endinterface

// configuration writes
interface bsfr_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/bsfr_front.sv @@
`timescale 1ns / 1ps

module bsfr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	bsfr_in_if.sink              items,
	input  bsfr_pkg::bsfr_cfg_t  cfg,
	input  bsfr_pkg::bsfr_qstat_t qstat,
	output logic                 push,
	output bsfr_pkg::bsfr_rec_t  push_rec
);

	logic [bsfr_pkg::CW-1:0] count_q;
	logic [7:0]              idle_q;
	logic [15:0]             sum_q;
	logic [bsfr_pkg::CW-1:0] last_q;
	logic                    hdr_bad_q;
	logic                    len_bad_q;
	logic                    sum_ok_q;
	logic [7:0]              id_q;
	logic [7:0]              stat_q;
	logic                    bat7_q;
	logic [7:0]              level_q;
	logic [7:0]              lo_q;

	logic                    acc;
	logic                    is_byte;
	logic                    is_tick;
	logic                    is_end;
	logic [bsfr_pkg::CW-1:0] p;
	logic [7:0]              b;
	logic                    in_sum;
	logic                    past_len;
	logic                    at_lo;
	logic                    at_hi;
	logic                    sum_ok_now;
	logic [7:0]              idle_inc;

	assign items.ready = !qstat.full;
	assign acc         = items.valid && items.ready;
	assign is_byte     = acc && !items.cmd;
	assign is_tick     = acc && items.cmd;
	assign p           = count_q;
	assign b           = items.rx_byte;
	assign is_end      = (p == bsfr_pkg::CW'(bsfr_pkg::FRAME_LEN - 1));

	// position decode for the running sum and the sum pair
	assign past_len   = (p > bsfr_pkg::CW'(bsfr_pkg::LEN_POS));
	assign in_sum     = (p != '0) && ((p <= bsfr_pkg::CW'(bsfr_pkg::LEN_POS)) || (p <= last_q));
	assign at_lo      = past_len && (p == last_q + bsfr_pkg::CW'(1));
	assign at_hi      = past_len && (p == last_q + bsfr_pkg::CW'(2));
	assign sum_ok_now = at_hi ? (sum_q == {b, lo_q}) : sum_ok_q;
	assign idle_inc   = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;

	// checks and classification on the last word of a frame
	always_comb begin
		push = is_byte && is_end;
		if (hdr_bad_q) begin
			push_rec.status = bsfr_pkg::ST_BAD_HDR;
		end else if (len_bad_q) begin
			push_rec.status = bsfr_pkg::ST_BAD_LEN;
		end else if (!sum_ok_now) begin
			push_rec.status = bsfr_pkg::ST_BAD_SUM;
		end else if (id_q != cfg.device_id) begin
			push_rec.status = bsfr_pkg::ST_OTHER_ID;
		end else begin
			push_rec.status = bsfr_pkg::ST_OK;
		end
		if (stat_q == 8'd0) begin
			push_rec.state = bsfr_pkg::PACK_EMPTY;
		end else if (stat_q == 8'd1) begin
			push_rec.state = bsfr_pkg::PACK_RESERVED;
		end else if (bat7_q || (level_q == bsfr_pkg::FULL_LEVEL)) begin
			push_rec.state = bsfr_pkg::PACK_FULL;
		end else begin
			push_rec.state = bsfr_pkg::PACK_CHARGING;
		end
		push_rec.level = level_q;
	end

	// frame position and idle count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idle_q  <= '0;
		end else if (is_byte) begin
			idle_q  <= '0;
			count_q <= is_end ? '0 : count_q + bsfr_pkg::CW'(1);
		end else if (is_tick && (count_q != '0)) begin
			if (idle_inc > cfg.idle_gap) begin
				count_q <= '0;
				idle_q  <= '0;
			end else begin
				idle_q <= idle_inc;
			end
		end
	end

	// captured fields and running sum
	always_ff @(posedge clk) begin
		if (is_byte) begin
			if (p == '0) begin
				hdr_bad_q <= (b != bsfr_pkg::SOF_BYTE);
				sum_q     <= '0;
				sum_ok_q  <= 1'b0;
			end else if (in_sum) begin
				sum_q <= sum_q + {8'h00, b};
			end
			if (p == bsfr_pkg::CW'(bsfr_pkg::ID_POS)) begin
				id_q <= b;
			end
			if ((p == bsfr_pkg::CW'(2)) && (b != bsfr_pkg::MARK_BYTE)) begin
				hdr_bad_q <= 1'b1;
			end
			if (p == bsfr_pkg::CW'(bsfr_pkg::LEN_POS)) begin
				len_bad_q <= (b > 8'(bsfr_pkg::MAX_LEN));
				last_q    <= bsfr_pkg::CW'(b) + bsfr_pkg::CW'(3);
			end
			if (p == bsfr_pkg::CW'(bsfr_pkg::STAT_POS)) begin
				stat_q <= b;
			end
			if (p == bsfr_pkg::CW'(bsfr_pkg::BAT8_POS)) begin
				bat7_q <= b[7];
			end
			if (p == bsfr_pkg::CW'(bsfr_pkg::LEVEL_POS)) begin
				level_q <= b;
			end
			if (at_lo) begin
				lo_q <= b;
			end
			if (at_hi) begin
				sum_ok_q <= sum_ok_now;
			end
		end
	end

endmodule

@@ rtl/bsfr_queue.sv @@
`timescale 1ns / 1ps

module bsfr_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  bsfr_pkg::bsfr_rec_t   push_rec,
	output bsfr_pkg::bsfr_qstat_t qstat,
	input  logic                  pop,
	output bsfr_pkg::bsfr_rec_t   head_rec
);

	bsfr_pkg::bsfr_rec_t      slot_q [bsfr_pkg::QDEPTH];
	logic [bsfr_pkg::QAW-1:0] wr_ptr_q;
	logic [bsfr_pkg::QAW-1:0] rd_ptr_q;
	logic [bsfr_pkg::QAW:0]   count_q;

	assign qstat.full  = (count_q == (bsfr_pkg::QAW+1)'(bsfr_pkg::QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign head_rec    = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + bsfr_pkg::QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bsfr_pkg::QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (bsfr_pkg::QAW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (bsfr_pkg::QAW+1)'(1);
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

@@ rtl/bsfr_back.sv @@
`timescale 1ns / 1ps

module bsfr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bsfr_pkg::bsfr_qstat_t qstat,
	input  bsfr_pkg::bsfr_rec_t   head_rec,
	output logic                  pop,
	bsfr_out_if.source            result
);

	bsfr_pkg::bsfr_bat_t    last_state_q;
	logic [7:0]             last_level_q;
	logic                   out_valid_q;
	bsfr_pkg::bsfr_status_t out_status_q;
	bsfr_pkg::bsfr_bat_t    out_state_q;
	logic [7:0]             out_level_q;
	logic                   out_update_q;
	logic                   ok;
	logic                   upd;

	assign pop = !qstat.empty && (!out_valid_q || result.ready);
	assign ok  = (head_rec.status == bsfr_pkg::ST_OK);
	assign upd = ok && ((head_rec.state != bsfr_pkg::PACK_CHARGING) ||
		(head_rec.state != last_state_q));

	assign result.valid         = out_valid_q;
	assign result.frame_status  = out_status_q;
	assign result.battery_state = out_state_q;
	assign result.charge_level  = out_level_q;
	assign result.update_screen = out_update_q;

	// stored battery state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_state_q <= bsfr_pkg::PACK_CHARGING;
			last_level_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop && ok) begin
				last_state_q <= head_rec.state;
				last_level_q <= head_rec.level;
			end
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (pop) begin
			out_status_q <= head_rec.status;
			out_state_q  <= ok ? head_rec.state : last_state_q;
			out_level_q  <= ok ? head_rec.level : last_level_q;
			out_update_q <= upd;
		end
	end

endmodule

@@ rtl/battery_status_frame_receiver.sv @@
`timescale 1ns / 1ps

// Battery status frame receiver. One word (a received byte or a millisecond tick) is taken
// every clock cycle while ready is high; the front keeps a running 16-bit sum and captures
// the frame fields as bytes arrive, so a 14-byte frame is checked as its last byte is taken
// and its result word reaches an output register through a two-entry queue, where checked
// frames wait between front and back, so ready drops only while that queue holds two results
// that the sink has not yet taken. Ticks and all bytes but the last of a frame give no result.
// Configuration writes are always ready and take effect in the next cycle.
module battery_status_frame_receiver (
	input  logic      clk,
	input  logic      arst_n,
	bsfr_in_if.sink   items,
	bsfr_out_if.source result,
	bsfr_cfg_if.sink  cfg
);

	bsfr_pkg::bsfr_cfg_t   cfg_q;
	bsfr_pkg::bsfr_qstat_t qstat;
	bsfr_pkg::bsfr_rec_t   push_rec;
	bsfr_pkg::bsfr_rec_t   head_rec;
	logic                  push;
	logic                  pop;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_id <= '0;
			cfg_q.idle_gap  <= bsfr_pkg::IDLE_GAP_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				bsfr_pkg::REG_DEVICE_ID: cfg_q.device_id <= cfg.data;
				bsfr_pkg::REG_IDLE_GAP:  cfg_q.idle_gap  <= cfg.data;
				default: ;
			endcase
		end
	end

	bsfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.cfg      (cfg_q),
		.qstat    (qstat),
		.push     (push),
		.push_rec (push_rec)
	);

	bsfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.qstat    (qstat),
		.pop      (pop),
		.head_rec (head_rec)
	);

	bsfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.head_rec (head_rec),
		.pop      (pop),
		.result   (result)
	);

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("result queue overflow");

	// a tick never produces a result
	a_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready && items.cmd) |-> !push)
		else $error("tick pushed a result");

	// a rejected frame never asks for a screen update
	a_reject_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.frame_status != bsfr_pkg::ST_OK)) |-> !result.update_screen)
		else $error("update flagged on rejected frame");

	// a push into an empty queue is popped in the following cycle while the output register is free
	a_push_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(push && qstat.empty && !result.valid) |=> pop)
		else $error("queued result not forwarded");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	// word kinds on the input channel
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// fixed frame positions not named in the package
	localparam int MARK_POS = 2;
	localparam int CR_POS   = bsfr_pkg::FRAME_LEN - 2;
	localparam int LF_POS   = bsfr_pkg::FRAME_LEN - 1;

	localparam logic [7:0] CR_BYTE = 8'h0D;
	localparam logic [7:0] LF_BYTE = 8'h0A;

	// cycles allowed for the pipeline to settle when nothing is expected
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BYTES  = 800;

	typedef logic [bsfr_pkg::FRAME_LEN-1:0][7:0] frame_t;

	typedef struct packed {
		bsfr_pkg::bsfr_status_t status;
		bsfr_pkg::bsfr_bat_t    state;
		logic [7:0]             level;
		logic                   update;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n;

	bsfr_in_if  items_if ();
	bsfr_out_if result_if ();
	bsfr_cfg_if cfg_if ();

	battery_status_frame_receiver i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// own copy of the receiver state and configuration
	logic [7:0]          frame_store [bsfr_pkg::FRAME_LEN];
	int                  store_count;
	int                  idle_count;
	bsfr_pkg::bsfr_bat_t held_state;
	logic [7:0]          held_level;
	logic [7:0]          cfg_device_id;
	logic [7:0]          cfg_idle_gap;

	frame_result_t pending_results [$];

	int  errors;
	int  bytes_sent;
	int  ticks_sent;
	int  results_seen;
	int  frames_taken;
	int  cfg_writes;
	bit  send_quiet;
	bit  sink_quiet;

	// header, length, sum and id checks on a complete frame
	function automatic bsfr_pkg::bsfr_status_t frame_verdict();
		int          len;
		int          i;
		logic [15:0] sum;
		logic [15:0] given;
		if (frame_store[0] != bsfr_pkg::SOF_BYTE ||
			frame_store[MARK_POS] != bsfr_pkg::MARK_BYTE)
			return bsfr_pkg::ST_BAD_HDR;
		len = int'(frame_store[bsfr_pkg::LEN_POS]);
		if (len > bsfr_pkg::MAX_LEN)
			return bsfr_pkg::ST_BAD_LEN;
		sum = '0;
		for (i = 1; i <= len + 3; i++)
			sum = sum + 16'(frame_store[i]);
		given = {frame_store[len + 5], frame_store[len + 4]};
		if (sum != given)
			return bsfr_pkg::ST_BAD_SUM;
		if (frame_store[bsfr_pkg::ID_POS] != cfg_device_id)
			return bsfr_pkg::ST_OTHER_ID;
		return bsfr_pkg::ST_OK;
	endfunction

	// advance the receiver state by one word; 1 when a result is due
	function automatic bit predict_word(input logic cmd, input logic [7:0] b,
		output frame_result_t r);
		bsfr_pkg::bsfr_status_t verdict;
		bsfr_pkg::bsfr_bat_t    cls;
		r.update = 1'b0;
		r.status = bsfr_pkg::ST_OK;
		r.state  = held_state;
		r.level  = held_level;
		if (cmd == CMD_TICK) begin
			if (store_count > 0) begin
				if (idle_count < 255)
					idle_count++;
				if (idle_count > int'(cfg_idle_gap)) begin
					store_count = 0;
					idle_count  = 0;
				end
			end
			return 1'b0;
		end
		frame_store[store_count] = b;
		store_count++;
		idle_count = 0;
		if (store_count < bsfr_pkg::FRAME_LEN)
			return 1'b0;
		store_count = 0;
		verdict = frame_verdict();
		if (verdict == bsfr_pkg::ST_OK) begin
			if (frame_store[bsfr_pkg::STAT_POS] == 8'd0)
				cls = bsfr_pkg::PACK_EMPTY;
			else if (frame_store[bsfr_pkg::STAT_POS] == 8'd1)
				cls = bsfr_pkg::PACK_RESERVED;
			else if (frame_store[bsfr_pkg::BAT8_POS][7] ||
				frame_store[bsfr_pkg::LEVEL_POS] == bsfr_pkg::FULL_LEVEL)
				cls = bsfr_pkg::PACK_FULL;
			else
				cls = bsfr_pkg::PACK_CHARGING;
			r.update   = (cls != bsfr_pkg::PACK_CHARGING) || (cls != held_state);
			held_state = cls;
			held_level = frame_store[bsfr_pkg::LEVEL_POS];
		end
		r.status = verdict;
		r.state  = held_state;
		r.level  = held_level;
		return 1'b1;
	endfunction

	// frame with a correct sum when its length field is in range; other bytes random
	function automatic frame_t make_frame(input logic [7:0] id, input logic [7:0] len,
		input logic [7:0] stat, input logic [7:0] bat8, input logic [7:0] level);
		frame_t      f;
		logic [15:0] sum;
		int          last;
		int          i;
		for (i = 0; i < bsfr_pkg::FRAME_LEN; i++)
			f[i] = 8'($urandom);
		f[0]                   = bsfr_pkg::SOF_BYTE;
		f[bsfr_pkg::ID_POS]    = id;
		f[MARK_POS]            = bsfr_pkg::MARK_BYTE;
		f[bsfr_pkg::LEN_POS]   = len;
		f[bsfr_pkg::STAT_POS]  = stat;
		f[bsfr_pkg::BAT8_POS]  = bat8;
		f[bsfr_pkg::LEVEL_POS] = level;
		f[CR_POS]              = CR_BYTE;
		f[LF_POS]              = LF_BYTE;
		if (int'(len) <= bsfr_pkg::MAX_LEN) begin
			last = int'(len) + 3;
			sum  = '0;
			for (i = 1; i <= last; i++)
				sum = sum + 16'(f[i]);
			f[last + 1] = sum[7:0];
			f[last + 2] = sum[15:8];
		end
		return f;
	endfunction

	// random frame, mostly well formed and addressed to us
	function automatic frame_t random_frame();
		logic [7:0] id;
		logic [7:0] len;
		logic [7:0] stat;
		logic [7:0] level;
		frame_t     f;
		id = ($urandom_range(0, 4) != 0) ? cfg_device_id : 8'($urandom);
		if ($urandom_range(0, 19) == 0)
			len = 8'($urandom_range(bsfr_pkg::MAX_LEN + 1, 255));
		else if ($urandom_range(0, 3) != 0)
			len = 8'd5;
		else
			len = 8'($urandom_range(0, bsfr_pkg::MAX_LEN));
		case ($urandom_range(0, 3))
			0: stat = 8'd0;
			1: stat = 8'd1;
			default: stat = 8'($urandom);
		endcase
		level = ($urandom_range(0, 3) == 0) ? bsfr_pkg::FULL_LEVEL : 8'($urandom);
		f = make_frame(id, len, stat, 8'($urandom), level);
		if ($urandom_range(0, 9) == 0)
			f[$urandom_range(0, bsfr_pkg::FRAME_LEN - 1)] ^= 8'(1 << $urandom_range(0, 7));
		return f;
	endfunction

	// send one word after a random gap and predict its effect
	task automatic send_word(input logic cmd, input logic [7:0] b);
		int            gap;
		frame_result_t r;
		gap = send_quiet ? 0 : $urandom_range(0, 11);
		if ($urandom_range(0, 63) == 0)
			send_quiet = !send_quiet;
		if (gap > 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_if.valid   <= 1'b1;
		items_if.cmd     <= cmd;
		items_if.rx_byte <= b;
		do
			@(posedge clk);
		while (!items_if.ready);
		if (cmd == CMD_TICK)
			ticks_sent++;
		else
			bytes_sent++;
		if (predict_word(cmd, b, r))
			pending_results.push_back(r);
	endtask

	task automatic send_tick();
		send_word(CMD_TICK, 8'($urandom));
	endtask

	// whole frame, optionally with ticks that keep it alive between bytes
	task automatic send_frame(input frame_t f, input bit with_ticks);
		int i;
		int k;
		for (i = 0; i < bsfr_pkg::FRAME_LEN; i++) begin
			send_word(CMD_BYTE, f[i]);
			if (with_ticks && i < bsfr_pkg::FRAME_LEN - 1 && $urandom_range(0, 5) == 0) begin
				k = $urandom_range(0, (cfg_idle_gap < 8'd3) ? int'(cfg_idle_gap) : 3);
				repeat (k) send_tick();
			end
		end
	endtask

	// get back onto a frame boundary
	task automatic resync();
		if (store_count != 0) begin
			if (cfg_idle_gap < 8'd40) begin
				repeat (int'(cfg_idle_gap) + 1) send_tick();
			end else begin
				while (store_count != 0)
					send_word(CMD_BYTE, 8'($urandom));
			end
		end
	endtask

	// hold off the sender until every expected result has come
	task automatic drain_results();
		items_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers while idle
	task automatic configure(input logic [7:0] id, input logic [7:0] gap);
		drain_results();
		cfg_if.valid <= 1'b1;
		cfg_if.index <= bsfr_pkg::REG_DEVICE_ID;
		cfg_if.data  <= id;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_device_id = id;
		cfg_if.index <= bsfr_pkg::REG_IDLE_GAP;
		cfg_if.data  <= gap;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_idle_gap = gap;
		cfg_if.valid <= 1'b0;
		cfg_writes += 2;
	endtask

	// reset values: id 0, gap 5, stored state charging
	task automatic test_after_reset();
		frame_t f;
		int     i;
		f = make_frame(8'd0, 8'd5, 8'd2, 8'h00, 8'd50);
		send_frame(f, 1'b0);
		// five idle ticks keep a partial frame, six drop it
		f = make_frame(8'd0, 8'd5, 8'd3, 8'h00, 8'd60);
		for (i = 0; i < 3; i++)
			send_word(CMD_BYTE, f[i]);
		repeat (5) send_tick();
		for (i = 3; i < bsfr_pkg::FRAME_LEN; i++)
			send_word(CMD_BYTE, f[i]);
		for (i = 0; i < 3; i++)
			send_word(CMD_BYTE, f[i]);
		repeat (6) send_tick();
		send_frame(f, 1'b0);
	endtask

	// each classification and each rejection
	task automatic test_frame_checks();
		frame_t f;
		configure(8'h5A, 8'd5);
		send_frame(make_frame(8'h5A, 8'd5, 8'd0, 8'h00, 8'd0), 1'b0);
		send_frame(make_frame(8'h5A, 8'd5, 8'd1, 8'h00, 8'd255), 1'b0);
		send_frame(make_frame(8'h5A, 8'd5, 8'd2, 8'h80, 8'd30), 1'b0);
		// length six keeps the level byte clear of the sum pair
		send_frame(make_frame(8'h5A, 8'd6, 8'hFF, 8'h7F, bsfr_pkg::FULL_LEVEL), 1'b0);
		// charging after full, then charging again with no change
		send_frame(make_frame(8'h5A, 8'd6, 8'd2, 8'h7F, 8'd99), 1'b0);
		send_frame(make_frame(8'h5A, 8'd6, 8'd2, 8'h00, 8'd101), 1'b0);
		// bad start byte, bad marker byte
		f = make_frame(8'h5A, 8'd5, 8'd0, 8'h00, 8'd10);
		f[0] = 8'h3B;
		send_frame(f, 1'b0);
		f = make_frame(8'h5A, 8'd5, 8'd0, 8'h00, 8'd10);
		f[MARK_POS] = 8'hFE;
		send_frame(f, 1'b0);
		// length one past the limit and at its top
		send_frame(make_frame(8'h5A, 8'(bsfr_pkg::MAX_LEN + 1), 8'd0, 8'h00, 8'd10), 1'b0);
		send_frame(make_frame(8'h5A, 8'd255, 8'd0, 8'h00, 8'd10), 1'b0);
		// broken sum, foreign id
		f = make_frame(8'h5A, 8'd5, 8'd0, 8'h00, 8'd10);
		f[bsfr_pkg::LEVEL_POS + 1] ^= 8'h01;
		send_frame(f, 1'b0);
		send_frame(make_frame(8'hA5, 8'd5, 8'd0, 8'h00, 8'd10), 1'b0);
		// shortest and longest length, sum moves with it
		send_frame(make_frame(8'h5A, 8'd0, 8'd2, 8'h00, 8'd40), 1'b0);
		send_frame(make_frame(8'h5A, 8'(bsfr_pkg::MAX_LEN), 8'd2, 8'h00, 8'd40), 1'b0);
	endtask

	// idle gap extremes and the saturating idle count
	task automatic test_idle_limits();
		frame_t f;
		int     i;
		configure(8'd255, 8'd0);
		repeat (3) send_tick();
		f = make_frame(8'd255, 8'd5, 8'd1, 8'h00, 8'd77);
		send_word(CMD_BYTE, f[0]);
		send_tick();
		send_frame(f, 1'b0);
		configure(8'd255, 8'd255);
		for (i = 0; i < 5; i++)
			send_word(CMD_BYTE, f[i]);
		repeat (300) send_tick();
		for (i = 5; i < bsfr_pkg::FRAME_LEN; i++)
			send_word(CMD_BYTE, f[i]);
	endtask

	// random traffic under one setting
	task automatic test_random_traffic(input logic [7:0] id, input logic [7:0] gap,
		input int n_bytes);
		int     start;
		int     k;
		int     i;
		bit     paused;
		frame_t f;
		configure(id, gap);
		start  = bytes_sent;
		paused = 1'b0;
		while (bytes_sent - start < n_bytes) begin
			if (!paused && bytes_sent - start >= n_bytes / 2) begin
				drain_results();
				paused = 1'b1;
			end
			k = $urandom_range(0, 99);
			if (k < 70) begin
				send_frame(random_frame(), 1'b1);
			end else if (k < 80) begin
				// partial frame left to be dropped or filled
				f = random_frame();
				for (i = 0; i < $urandom_range(1, bsfr_pkg::FRAME_LEN - 1); i++)
					send_word(CMD_BYTE, f[i]);
				resync();
			end else if (k < 90) begin
				// stray words, sometimes left misaligned
				repeat ($urandom_range(1, 5))
					send_word(1'($urandom), 8'($urandom));
				if ($urandom_range(0, 2) != 0 && cfg_idle_gap != 8'd255)
					resync();
			end else begin
				repeat ($urandom_range(1, 4)) send_tick();
			end
		end
		resync();
	endtask

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result word with no frame pending");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (want.status == bsfr_pkg::ST_OK)
					frames_taken++;
				if (result_if.frame_status != want.status) begin
					$error("frame_status: expected %0d, got %0d", want.status,
						result_if.frame_status);
					errors++;
				end
				if (result_if.battery_state != want.state) begin
					$error("battery_state: expected %0d, got %0d", want.state,
						result_if.battery_state);
					errors++;
				end
				if (result_if.charge_level != want.level) begin
					$error("charge_level: expected %0d, got %0d", want.level,
						result_if.charge_level);
					errors++;
				end
				if (result_if.update_screen != want.update) begin
					$error("update_screen: expected %0d, got %0d", want.update,
						result_if.update_screen);
					errors++;
				end
			end
		end
	end

	// result sink with random stalls
	initial begin : result_sink
		int stall;
		result_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = sink_quiet ? 0 : $urandom_range(0, 11);
			if ($urandom_range(0, 63) == 0)
				sink_quiet = !sink_quiet;
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(result_if.valid && result_if.ready));
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("battery_status_frame_receiver regression: fail");
		$finish;
	end

	// test sequence
	initial begin
		items_if.valid   <= 1'b0;
		items_if.cmd     <= CMD_BYTE;
		items_if.rx_byte <= 8'h00;
		cfg_if.valid     <= 1'b0;
		cfg_if.index     <= bsfr_pkg::REG_DEVICE_ID;
		cfg_if.data      <= 8'h00;
		arst_n           <= 1'b0;
		errors        = 0;
		bytes_sent    = 0;
		ticks_sent    = 0;
		results_seen  = 0;
		frames_taken  = 0;
		cfg_writes    = 0;
		send_quiet    = 1'b0;
		sink_quiet    = 1'b0;
		store_count   = 0;
		idle_count    = 0;
		held_state    = bsfr_pkg::PACK_CHARGING;
		held_level    = 8'h00;
		cfg_device_id = 8'h00;
		cfg_idle_gap  = bsfr_pkg::IDLE_GAP_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_frame_checks();
		test_idle_limits();
		test_random_traffic(8'($urandom), 8'd5, RANDOM_BYTES / 5);
		test_random_traffic(8'd0, 8'd0, RANDOM_BYTES / 5);
		test_random_traffic(8'd255, 8'd255, RANDOM_BYTES / 5);
		test_random_traffic(8'($urandom), 8'($urandom_range(1, 20)), RANDOM_BYTES / 5);
		test_random_traffic(8'($urandom), 8'd3, RANDOM_BYTES / 5);

		drain_results();
		$display("sent %0d bytes and %0d ticks over %0d register writes", bytes_sent,
			ticks_sent, cfg_writes);
		$display("checked %0d frame results, %0d of them accepted frames", results_seen,
			frames_taken);
		if (errors == 0)
			$display("battery_status_frame_receiver regression: pass");
		else
			$display("battery_status_frame_receiver regression: fail");
		$finish;
	end

endmodule
